FILE: rtl/hstd_pkg.sv
// shared types and constants for the serialized-tree huffman decoder
`timescale 1ns / 1ps
package hstd_pkg;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;
  localparam logic [1:0] OP_BIT   = 2'd3;

  localparam logic [7:0] BYTE_LEAF   = 8'h4C;
  localparam logic [7:0] BYTE_BRANCH = 8'h42;
  localparam logic [7:0] SYM_NONE    = 8'h00;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_FULL      = 3'd3,
    ST_NO_TREE   = 3'd4,
    ST_SINGLE    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP2,
    S_END_CHK,
    S_END_RD,
    S_END_NODE
  } state_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_BEGIN,
    ACT_AWAIT,
    ACT_FAIL,
    ACT_END_FAIL,
    ACT_PUSH_LEAF,
    ACT_PUSH_BRANCH,
    ACT_LOAD_ROOT,
    ACT_STEP
  } act_t;

  typedef struct packed {
    logic    accept;
    logic    pop_rd;
    logic    stk0_rd;
    logic    root_rd;
    act_t    act;
    logic    emit;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       leaf_byte;
    logic       branch_byte;
    logic       awaiting;
    logic       failed;
    logic       ready;
    logic       root_leaf;
    logic       depth_lt2;
    logic       full;
    logic       depth_one;
    logic       out_free;
  } stat_t;

endpackage

FILE: rtl/hstd_ctrl.sv
// controller state machine: sequences memory accesses and result writes per request
`timescale 1ns / 1ps
module hstd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hstd_pkg::stat_t stat,
  output hstd_pkg::cmd_t  cmd
);

  hstd_pkg::state_t  state;
  hstd_pkg::state_t  state_next;
  logic              done;
  hstd_pkg::act_t    done_act;
  hstd_pkg::status_t done_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hstd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == hstd_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.act    = hstd_pkg::ACT_NONE;
    cmd.code   = hstd_pkg::ST_OK;
    done       = 1'b0;
    done_act   = hstd_pkg::ACT_NONE;
    done_code  = hstd_pkg::ST_OK;
    case (state)
      hstd_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = hstd_pkg::S_EXEC;
        end
      end
      hstd_pkg::S_EXEC: begin
        case (stat.op)
          hstd_pkg::OP_BEGIN: begin
            done     = 1'b1;
            done_act = hstd_pkg::ACT_BEGIN;
          end
          hstd_pkg::OP_BYTE: begin
            if (stat.failed || stat.ready) begin
              done = 1'b1;
            end else if (stat.awaiting) begin
              done = 1'b1;
              if (stat.full) begin
                done_act  = hstd_pkg::ACT_FAIL;
                done_code = hstd_pkg::ST_FULL;
              end else begin
                done_act = hstd_pkg::ACT_PUSH_LEAF;
              end
            end else if (stat.leaf_byte) begin
              done     = 1'b1;
              done_act = hstd_pkg::ACT_AWAIT;
            end else if (stat.branch_byte) begin
              if (stat.depth_lt2) begin
                done      = 1'b1;
                done_act  = hstd_pkg::ACT_FAIL;
                done_code = hstd_pkg::ST_UNDERFLOW;
              end else if (stat.full) begin
                done      = 1'b1;
                done_act  = hstd_pkg::ACT_FAIL;
                done_code = hstd_pkg::ST_FULL;
              end else begin
                // right child is in the stack read register, fetch the left one
                cmd.pop_rd = 1'b1;
                state_next = hstd_pkg::S_POP2;
              end
            end else begin
              done = 1'b1;
            end
          end
          hstd_pkg::OP_END: begin
            if (stat.awaiting && !stat.failed && !stat.ready) begin
              if (stat.full) begin
                done      = 1'b1;
                done_act  = hstd_pkg::ACT_FAIL;
                done_code = hstd_pkg::ST_FULL;
              end else begin
                // trailing leaf with no symbol byte
                cmd.act    = hstd_pkg::ACT_PUSH_LEAF;
                state_next = hstd_pkg::S_END_CHK;
              end
            end else begin
              state_next = hstd_pkg::S_END_CHK;
            end
          end
          hstd_pkg::OP_BIT: begin
            done = 1'b1;
            if (!stat.ready) begin
              done_code = hstd_pkg::ST_NO_TREE;
            end else if (stat.root_leaf) begin
              done_code = hstd_pkg::ST_SINGLE;
            end else begin
              done_act = hstd_pkg::ACT_STEP;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      hstd_pkg::S_POP2: begin
        done     = 1'b1;
        done_act = hstd_pkg::ACT_PUSH_BRANCH;
      end
      hstd_pkg::S_END_CHK: begin
        if (stat.failed || !stat.depth_one) begin
          done      = 1'b1;
          done_act  = hstd_pkg::ACT_END_FAIL;
          done_code = hstd_pkg::ST_MALFORMED;
        end else begin
          cmd.stk0_rd = 1'b1;
          state_next  = hstd_pkg::S_END_RD;
        end
      end
      hstd_pkg::S_END_RD: begin
        cmd.root_rd = 1'b1;
        state_next  = hstd_pkg::S_END_NODE;
      end
      hstd_pkg::S_END_NODE: begin
        done     = 1'b1;
        done_act = hstd_pkg::ACT_LOAD_ROOT;
      end
      default: begin
        state_next = hstd_pkg::S_IDLE;
      end
    endcase
    // finishing actions wait for a free result slot
    if (done && stat.out_free) begin
      cmd.act    = done_act;
      cmd.emit   = 1'b1;
      cmd.code   = done_code;
      state_next = hstd_pkg::S_IDLE;
    end
  end

endmodule

FILE: rtl/hstd_datapath.sv
// datapath: node store, build stack, tree walk registers and result register
`timescale 1ns / 1ps
module hstd_datapath #(
  parameter int MAX_NODES = 512
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      op,
  input  logic [7:0]      tree_byte,
  input  logic            code_bit,
  input  hstd_pkg::cmd_t  cmd,
  output hstd_pkg::stat_t stat,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            symbol_valid,
  output logic [7:0]      symbol,
  output logic [2:0]      status
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int NW = 1 + 8 + 2 * IW;

  // node word: leaf flag, symbol, left index, right index
  logic [NW-1:0] node_mem [MAX_NODES];
  logic [IW-1:0] stk_mem  [MAX_NODES];

  logic [CW-1:0] node_count;
  logic [CW-1:0] stack_depth;
  logic          awaiting;
  logic          failed;
  logic          ready;
  logic          root_leaf;
  logic [IW-1:0] root_left;
  logic [IW-1:0] root_right;
  logic [IW-1:0] cur_left;
  logic [IW-1:0] cur_right;
  logic [IW-1:0] right_idx;
  logic [1:0]    op_q;
  logic [7:0]    byte_q;
  logic [NW-1:0] node_q;
  logic [IW-1:0] stk_q;
  hstd_pkg::status_t status_q;

  logic          node_we;
  logic [NW-1:0] node_wd;
  logic          node_re;
  logic [IW-1:0] node_ra;
  logic          stk_we;
  logic [IW-1:0] stk_wa;
  logic          stk_re;
  logic [IW-1:0] stk_ra;
  logic [CW-1:0] depth_m1;
  logic [CW-1:0] depth_m2;
  logic          q_leaf;
  logic [7:0]    q_sym;
  logic [IW-1:0] q_left;
  logic [IW-1:0] q_right;
  logic [7:0]    leaf_sym;

  assign depth_m1 = stack_depth - CW'(1);
  assign depth_m2 = stack_depth - CW'(2);
  assign {q_leaf, q_sym, q_left, q_right} = node_q;
  assign leaf_sym = (op_q == hstd_pkg::OP_BYTE) ? byte_q : hstd_pkg::SYM_NONE;

  // write side of both memories
  always_comb begin
    node_we = 1'b0;
    node_wd = {1'b1, leaf_sym, {IW{1'b0}}, {IW{1'b0}}};
    stk_we  = 1'b0;
    stk_wa  = stack_depth[IW-1:0];
    case (cmd.act)
      hstd_pkg::ACT_PUSH_LEAF: begin
        node_we = 1'b1;
        stk_we  = 1'b1;
      end
      hstd_pkg::ACT_PUSH_BRANCH: begin
        node_we = 1'b1;
        node_wd = {1'b0, hstd_pkg::SYM_NONE, stk_q, right_idx};
        stk_we  = 1'b1;
        stk_wa  = depth_m2[IW-1:0];
      end
      default: begin
        node_we = 1'b0;
      end
    endcase
  end

  // read side: child fetch on accept, root fetch at end of tree
  assign node_re = cmd.accept | cmd.root_rd;
  assign node_ra = cmd.root_rd ? stk_q : (code_bit ? cur_right : cur_left);
  assign stk_re  = cmd.accept | cmd.pop_rd | cmd.stk0_rd;

  always_comb begin
    if (cmd.stk0_rd) begin
      stk_ra = '0;
    end else if (cmd.pop_rd) begin
      stk_ra = depth_m2[IW-1:0];
    end else begin
      stk_ra = depth_m1[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_count[IW-1:0]] <= node_wd;
    end
    if (node_re) begin
      node_q <= node_mem[node_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= node_count[IW-1:0];
    end
    if (stk_re) begin
      stk_q <= stk_mem[stk_ra];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= op;
      byte_q <= tree_byte;
    end
    if (cmd.pop_rd) begin
      right_idx <= stk_q;
    end
    if (cmd.act == hstd_pkg::ACT_LOAD_ROOT) begin
      root_leaf  <= q_leaf;
      root_left  <= q_left;
      root_right <= q_right;
      cur_left   <= q_left;
      cur_right  <= q_right;
    end else if (cmd.act == hstd_pkg::ACT_STEP) begin
      if (q_leaf) begin
        cur_left  <= root_left;
        cur_right <= root_right;
      end else begin
        cur_left  <= q_left;
        cur_right <= q_right;
      end
    end
    if (cmd.emit) begin
      status_q     <= cmd.code;
      symbol_valid <= (cmd.act == hstd_pkg::ACT_STEP) && q_leaf;
      symbol       <= ((cmd.act == hstd_pkg::ACT_STEP) && q_leaf) ? q_sym : hstd_pkg::SYM_NONE;
    end
  end

  // build and result control
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= '0;
      stack_depth <= '0;
      awaiting    <= 1'b0;
      failed      <= 1'b0;
      ready       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      case (cmd.act)
        hstd_pkg::ACT_BEGIN: begin
          node_count  <= '0;
          stack_depth <= '0;
          awaiting    <= 1'b0;
          failed      <= 1'b0;
          ready       <= 1'b0;
        end
        hstd_pkg::ACT_AWAIT: begin
          awaiting <= 1'b1;
        end
        hstd_pkg::ACT_FAIL: begin
          failed   <= 1'b1;
          awaiting <= 1'b0;
        end
        hstd_pkg::ACT_END_FAIL: begin
          failed   <= 1'b1;
          ready    <= 1'b0;
          awaiting <= 1'b0;
        end
        hstd_pkg::ACT_PUSH_LEAF: begin
          node_count  <= node_count + CW'(1);
          stack_depth <= stack_depth + CW'(1);
          awaiting    <= 1'b0;
        end
        hstd_pkg::ACT_PUSH_BRANCH: begin
          node_count  <= node_count + CW'(1);
          stack_depth <= depth_m1;
        end
        hstd_pkg::ACT_LOAD_ROOT: begin
          ready    <= 1'b1;
          awaiting <= 1'b0;
        end
        default: begin
          ready <= ready;
        end
      endcase
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status = status_q;

  always_comb begin
    stat             = '0;
    stat.op          = op_q;
    stat.leaf_byte   = (byte_q == hstd_pkg::BYTE_LEAF);
    stat.branch_byte = (byte_q == hstd_pkg::BYTE_BRANCH);
    stat.awaiting    = awaiting;
    stat.failed      = failed;
    stat.ready       = ready;
    stat.root_leaf   = root_leaf;
    stat.depth_lt2   = (stack_depth < CW'(2));
    stat.full        = (node_count >= CW'(MAX_NODES)) || (stack_depth >= CW'(MAX_NODES));
    stat.depth_one   = (stack_depth == CW'(1));
    stat.out_free    = !out_valid || out_ready;
  end

  a_depth_le_count: assert property (@(posedge clk) disable iff (rst)
    stack_depth <= node_count)
    else $error("stack holds more entries than nodes built");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= CW'(MAX_NODES))
    else $error("node count past store size");

  a_ready_not_failed: assert property (@(posedge clk) disable iff (rst)
    ready |-> !failed)
    else $error("tree ready while build marked failed");

  a_sym_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !symbol_valid) |-> (symbol == hstd_pkg::SYM_NONE))
    else $error("symbol not cleared on a result without a leaf");

  a_sym_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && symbol_valid) |-> (status_q == hstd_pkg::ST_OK))
    else $error("symbol emitted with an error status");

endmodule

FILE: rtl/huffman_serialized_tree_decoder.sv
// top level: huffman decoder that rebuilds its tree from a post-order serialization
//
//   channel   handshake            payload
//   input     in_valid / in_ready  op, tree_byte, code_bit
//   output    out_valid / out_ready  symbol_valid, symbol, status
//
// one request at a time; begin, tree bytes and code bits are accepted and run; a branch
// byte joining two nodes adds a pop (two reads of the single stack port), a failing end an
// end check (none if the trailing leaf finds a full store), a good end that check plus two
// reads (stack then node store read of the root). a code bit is one node store read of the
// child, addressed by the cached children of the current node. a new request is taken
// while a result waits; the next one completes only when the output register is free.
// reset clears the build state and marks no tree; the memories need no clearing pass.
`timescale 1ns / 1ps
module huffman_serialized_tree_decoder #(
  parameter int MAX_NODES = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [7:0] tree_byte,
  input  logic       code_bit,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       symbol_valid,
  output logic [7:0] symbol,
  output logic [2:0] status
);

  hstd_pkg::cmd_t  cmd;
  hstd_pkg::stat_t stat;

  hstd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hstd_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .tree_byte    (tree_byte),
    .code_bit     (code_bit),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .symbol_valid (symbol_valid),
    .symbol       (symbol),
    .status       (status)
  );

endmodule

FILE: test/huffman_serialized_tree_decoder_tb.sv
// testbench for the serialized-tree huffman decoder: directed and random requests, scoreboard
`timescale 1ns / 1ps
module huffman_serialized_tree_decoder_tb;

  localparam int NODE_LIMIT = 512;
  localparam int TOTAL_REQS = 1430;
  localparam int TIMEOUT_NS = 5_000_000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic               sym_ok;
    logic [7:0]         sym;
    hstd_pkg::status_t  st;
  } decode_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] op = hstd_pkg::OP_BEGIN;
  logic [7:0] tree_byte = 8'h00;
  logic       code_bit = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       symbol_valid;
  logic [7:0] symbol;
  logic [2:0] status;

  huffman_serialized_tree_decoder #(
    .MAX_NODES(NODE_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .tree_byte(tree_byte),
    .code_bit(code_bit),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .symbol_valid(symbol_valid),
    .symbol(symbol),
    .status(status)
  );

  always #5 clk = ~clk;

  // shadow copy of the decoder's tree and walk state
  logic       nd_leaf  [NODE_LIMIT];
  logic [7:0] nd_sym   [NODE_LIMIT];
  logic [8:0] nd_left  [NODE_LIMIT];
  logic [8:0] nd_right [NODE_LIMIT];
  logic [8:0] stk_idx  [NODE_LIMIT];
  int         node_cnt = 0;
  int         stk_depth = 0;
  logic       want_sym = 1'b0;
  logic       have_tree = 1'b0;
  logic       build_bad = 1'b0;
  logic [8:0] root_idx = '0;
  logic [8:0] walk_idx = '0;

  decode_out_t pending_symbols[$];
  int          mismatch_count = 0;
  int          reqs_sent = 0;
  int          burst_left = 0;

  function automatic hstd_pkg::status_t add_node(logic lf, logic [7:0] s,
                                                 logic [8:0] l, logic [8:0] r);
    if (node_cnt >= NODE_LIMIT || stk_depth >= NODE_LIMIT) begin
      build_bad = 1'b1;
      return hstd_pkg::ST_FULL;
    end
    nd_leaf[node_cnt] = lf;
    nd_sym[node_cnt] = s;
    nd_left[node_cnt] = l;
    nd_right[node_cnt] = r;
    stk_idx[stk_depth] = 9'(node_cnt);
    node_cnt++;
    stk_depth++;
    return hstd_pkg::ST_OK;
  endfunction

  function automatic decode_out_t decode_step(logic [1:0] o, logic [7:0] b, logic c);
    decode_out_t res;
    logic [8:0]  nxt;
    res.sym_ok = 1'b0;
    res.sym = hstd_pkg::SYM_NONE;
    res.st = hstd_pkg::ST_OK;
    case (o)
      hstd_pkg::OP_BEGIN: begin
        node_cnt = 0;
        stk_depth = 0;
        want_sym = 1'b0;
        have_tree = 1'b0;
        build_bad = 1'b0;
        walk_idx = '0;
      end
      hstd_pkg::OP_BYTE: begin
        if (!build_bad && !have_tree) begin
          if (want_sym) begin
            want_sym = 1'b0;
            res.st = add_node(1'b1, b, '0, '0);
          end else if (b == hstd_pkg::BYTE_LEAF) begin
            want_sym = 1'b1;
          end else if (b == hstd_pkg::BYTE_BRANCH) begin
            if (stk_depth < 2) begin
              build_bad = 1'b1;
              res.st = hstd_pkg::ST_UNDERFLOW;
            end else if (node_cnt >= NODE_LIMIT) begin
              build_bad = 1'b1;
              res.st = hstd_pkg::ST_FULL;
            end else begin
              stk_depth -= 2;
              res.st = add_node(1'b0, hstd_pkg::SYM_NONE, stk_idx[stk_depth],
                                stk_idx[stk_depth + 1]);
            end
          end
        end
      end
      hstd_pkg::OP_END: begin
        // a dangling leaf marker becomes a leaf with symbol zero
        if (want_sym && !build_bad && !have_tree) begin
          want_sym = 1'b0;
          res.st = add_node(1'b1, hstd_pkg::SYM_NONE, '0, '0);
          if (res.st != hstd_pkg::ST_OK) have_tree = 1'b0;
        end
        if (res.st == hstd_pkg::ST_OK) begin
          want_sym = 1'b0;
          if (build_bad || stk_depth != 1) begin
            build_bad = 1'b1;
            have_tree = 1'b0;
            res.st = hstd_pkg::ST_MALFORMED;
          end else begin
            root_idx = stk_idx[0];
            walk_idx = root_idx;
            have_tree = 1'b1;
          end
        end
      end
      default: begin
        if (!have_tree) begin
          res.st = hstd_pkg::ST_NO_TREE;
        end else if (nd_leaf[root_idx]) begin
          res.st = hstd_pkg::ST_SINGLE;
        end else begin
          nxt = c ? nd_right[walk_idx] : nd_left[walk_idx];
          if (nd_leaf[nxt]) begin
            res.sym_ok = 1'b1;
            res.sym = nd_sym[nxt];
            walk_idx = root_idx;
          end else begin
            walk_idx = nxt;
          end
        end
      end
    endcase
    return res;
  endfunction

  // send one request, sometimes opening a gap between bursts
  task automatic issue(input logic [1:0] o, input logic [7:0] b, input logic c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    op <= o;
    tree_byte <= b;
    code_bit <= c;
    do @(posedge clk); while (!in_ready);
    pending_symbols.push_back(decode_step(o, b, c));
    reqs_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    issue(hstd_pkg::OP_BYTE, b, 1'($urandom_range(1)));
  endtask

  task automatic send_cmd(input logic [1:0] o);
    issue(o, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic send_bit(input logic c);
    issue(hstd_pkg::OP_BIT, 8'($urandom_range(255)), c);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == hstd_pkg::BYTE_LEAF || b == hstd_pkg::BYTE_BRANCH);
    return b;
  endfunction

  task automatic test_no_tree();
    send_bit(1'b0);
    send_cmd(hstd_pkg::OP_END);
  endtask

  task automatic test_basic_walk();
    send_cmd(hstd_pkg::OP_BEGIN);
    send_byte(hstd_pkg::BYTE_LEAF);
    send_byte(hstd_pkg::BYTE_LEAF);
    send_byte(hstd_pkg::BYTE_LEAF);
    send_byte(hstd_pkg::BYTE_BRANCH);
    send_byte(hstd_pkg::BYTE_BRANCH);
    send_byte(8'h7F);
    send_cmd(hstd_pkg::OP_END);
    send_bit(1'b0);
    send_bit(1'b1);
    // tree is locked after end
    send_byte(hstd_pkg::BYTE_LEAF);
    send_cmd(hstd_pkg::OP_END);
    send_bit(1'b1);
  endtask

  task automatic test_bad_builds();
    send_cmd(hstd_pkg::OP_BEGIN);
    send_byte(hstd_pkg::BYTE_BRANCH);
    send_byte(hstd_pkg::BYTE_LEAF);
    send_cmd(hstd_pkg::OP_END);
    send_cmd(hstd_pkg::OP_BEGIN);
    send_byte(hstd_pkg::BYTE_LEAF);
    send_byte(8'hFF);
    send_bit(1'b1);
    send_cmd(hstd_pkg::OP_END);
    send_bit(1'b0);
    send_cmd(hstd_pkg::OP_BEGIN);
    send_byte(hstd_pkg::BYTE_LEAF);
    send_cmd(hstd_pkg::OP_END);
  endtask

  // chain of leaf/branch pairs up to the node store limit, then one node too many
  task automatic test_store_full();
    send_cmd(hstd_pkg::OP_BEGIN);
    send_byte(hstd_pkg::BYTE_LEAF);
    send_byte(8'($urandom_range(255)));
    repeat (NODE_LIMIT / 2 - 1) begin
      send_byte(hstd_pkg::BYTE_LEAF);
      send_byte(8'($urandom_range(255)));
      send_byte(hstd_pkg::BYTE_BRANCH);
    end
    send_byte(hstd_pkg::BYTE_LEAF);
    send_byte(8'($urandom_range(255)));
    case ($urandom_range(2))
      0: send_byte(hstd_pkg::BYTE_BRANCH);
      1: begin
        send_byte(hstd_pkg::BYTE_LEAF);
        send_byte(8'($urandom_range(255)));
      end
      default: begin
        send_byte(hstd_pkg::BYTE_LEAF);
        send_cmd(hstd_pkg::OP_END);
      end
    endcase
    send_cmd(hstd_pkg::OP_END);
  endtask

  task automatic build_and_walk();
    int leaves_left;
    int depth;
    int n;
    n = ($urandom_range(7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
    leaves_left = n;
    depth = 0;
    send_cmd(hstd_pkg::OP_BEGIN);
    while (leaves_left > 0 || depth > 1) begin
      if (leaves_left > 0 && (depth < 2 || $urandom_range(1) == 1)) begin
        send_byte(hstd_pkg::BYTE_LEAF);
        // lone leaf may rely on end to supply its symbol
        if (!(n == 1 && $urandom_range(3) == 0)) send_byte(8'($urandom_range(255)));
        leaves_left--;
        depth++;
      end else begin
        send_byte(hstd_pkg::BYTE_BRANCH);
        depth--;
      end
      if ($urandom_range(9) == 0) send_byte(noise_byte());
    end
    send_cmd(hstd_pkg::OP_END);
    repeat ($urandom_range(5, 30)) begin
      case ($urandom_range(29))
        0: send_cmd(hstd_pkg::OP_END);
        1: send_byte(8'($urandom_range(255)));
        default: send_bit(1'($urandom_range(1)));
      endcase
    end
  endtask

  task automatic random_noise();
    int         k;
    logic [1:0] o;
    logic [7:0] b;
    repeat ($urandom_range(4, 16)) begin
      k = $urandom_range(9);
      o = (k < 1) ? hstd_pkg::OP_BEGIN :
          (k < 6) ? hstd_pkg::OP_BYTE :
          (k < 7) ? hstd_pkg::OP_END : hstd_pkg::OP_BIT;
      k = $urandom_range(9);
      b = (k < 4) ? hstd_pkg::BYTE_LEAF :
          (k < 7) ? hstd_pkg::BYTE_BRANCH : 8'($urandom_range(255));
      issue(o, b, 1'($urandom_range(1)));
    end
  endtask

  task automatic test_random();
    while (reqs_sent < TOTAL_REQS) begin
      if ($urandom_range(3) == 0) random_noise();
      else build_and_walk();
      if ($urandom_range(19) == 0) wait_for_results();
    end
  endtask

  // receiver stalls follow a mode that changes every so often
  int ready_mode = 0;
  int ready_span = 0;
  int ready_tick = 0;
  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mode = $urandom_range(3);
      ready_span = $urandom_range(20, 200);
    end else begin
      ready_span--;
    end
    ready_tick++;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(1));
      2: out_ready <= ($urandom_range(7) == 0);
      default: out_ready <= (ready_tick % 5) < 2;
    endcase
  end

  always @(posedge clk) begin
    decode_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_symbols.size() == 0) begin
        $error("result with no request outstanding: symbol_valid=%0d symbol=%0h status=%0d",
               symbol_valid, symbol, status);
        mismatch_count++;
      end else begin
        want = pending_symbols.pop_front();
        if (symbol_valid !== want.sym_ok) begin
          $error("symbol_valid: expected %0d, actual %0d", want.sym_ok, symbol_valid);
          mismatch_count++;
        end
        if (symbol !== want.sym) begin
          $error("symbol: expected %0h, actual %0h", want.sym, symbol);
          mismatch_count++;
        end
        if (status !== want.st) begin
          $error("status: expected %0d, actual %0d", want.st, status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_no_tree();
    test_basic_walk();
    test_bad_builds();
    wait_for_results();
    test_store_full();
    wait_for_results();
    test_random();
    wait_for_results();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/hstd_pkg.sv
rtl/hstd_ctrl.sv
rtl/hstd_datapath.sv
rtl/huffman_serialized_tree_decoder.sv
test/huffman_serialized_tree_decoder_tb.sv
